// File: design/hntt_pkg.sv
package hntt_pkg;

	// Table sizing
	localparam int BUCKETS = 10;
	localparam int POOL    = 1024;

	// Field widths
	localparam int NAME_W = 48;
	localparam int ID_W   = 10;

	// Derived widths
	localparam int H_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int CNT_W = $clog2(POOL + 1);   // holds the empty marker POOL
	localparam int ENT_W = NAME_W + CNT_W;     // stored name plus chain link

	// djb2 step: x = h*33 + c, with h < BUCKETS and c < 256
	localparam int X_W = $clog2(33 * BUCKETS + 256);
	localparam int H0  = 5381 % BUCKETS;

	// Reciprocal for the mod-BUCKETS reduction, exact for x below 2^16+
	localparam int RSHIFT = 32;
	localparam int RCP_W  = 33;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RSHIFT) / BUCKETS + 1);
	localparam int PROD_W = X_W + RCP_W;

	localparam logic [CNT_W-1:0] EMPTY = CNT_W'(POOL);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_RED,
		S_HEAD,
		S_CMP,
		S_EMIT
	} hntt_state_t;

endpackage

// File: design/hntt_ram.sv
module hntt_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/hashed_name_to_id_table.sv
// Channel  | Signals                                  | Item
// ---------+------------------------------------------+---------------------------------
// in       | in_valid, in_ready, name_chars[47:0]     | name, first char in top byte
// out      | out_valid, out_ready, entry_id[9:0],     | id, inserted flag, full flag
//          | was_new, table_full                      |
//
// Flow: after acceptance each byte of the name (0..6 bytes) takes a HASH and a RED
// step, a final HASH sees the zero byte, then HEAD, one CMP per chain entry compared
// (none on an empty bucket) and EMIT. The shared mod-BUCKETS reducer works one byte at a time;
// the single entry RAM read port walks one chain entry per cycle.
// Reset clears the bucket heads and the entry count at once; no clearing pass.
// One item at a time; a new item is taken while the previous result still
// waits in the output register. A stalled result holds the sequencer in EMIT.
module hashed_name_to_id_table
	import hntt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NAME_W-1:0] name_chars,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ID_W-1:0]   entry_id,
	output logic              was_new,
	output logic              table_full
);

	hntt_state_t state_q, state_d;

	// Item under work
	logic [NAME_W-1:0] norm_q;
	logic [H_W-1:0]    h_q;
	logic [2:0]        byte_q;
	logic [X_W-1:0]    x_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  cur_q;

	// Table state
	logic [CNT_W-1:0]  head_q [BUCKETS];
	logic [CNT_W-1:0]  count_q;

	// Pending and delivered result
	logic [ID_W-1:0]   res_id_q;
	logic              res_new_q;
	logic              res_full_q;
	logic              out_valid_q;
	logic [ID_W-1:0]   entry_id_q;
	logic              was_new_q;
	logic              table_full_q;

	// Normalize: zero every byte after the first zero byte
	logic [NAME_W-1:0] norm_in;
	always_comb begin
		logic alive;
		alive   = 1'b1;
		norm_in = '0;
		for (int i = 0; i < 6; i++) begin
			if (name_chars[NAME_W-1-8*i -: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				norm_in[NAME_W-1-8*i -: 8] = name_chars[NAME_W-1-8*i -: 8];
			end
		end
	end

	// Current byte; shift of 48 at byte six yields zero, ending the hash
	logic [NAME_W-1:0] norm_sh;
	logic [7:0]        cur_byte;
	assign norm_sh  = norm_q << {byte_q, 3'b000};
	assign cur_byte = norm_sh[NAME_W-1 -: 8];

	// Shared hash unit: multiply by reciprocal, then subtract and correct
	logic [X_W-1:0]    x_new;
	logic [X_W-1:0]    quot;
	logic [X_W-1:0]    qb;
	logic [X_W-1:0]    rem0;
	logic [X_W-1:0]    rem;
	assign x_new = X_W'({h_q, 5'b00000}) + X_W'(h_q) + X_W'(cur_byte);
	assign quot  = prod_q[RSHIFT +: X_W];
	assign qb    = X_W'(quot * X_W'(BUCKETS));
	assign rem0  = x_q - qb;
	assign rem   = (rem0 >= X_W'(BUCKETS)) ? rem0 - X_W'(BUCKETS) : rem0;

	// Entry RAM: {name, link}
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	logic [NAME_W-1:0] rd_name;
	logic [CNT_W-1:0]  rd_link;
	assign rd_name = ram_rdata[ENT_W-1 -: NAME_W];
	assign rd_link = ram_rdata[CNT_W-1:0];

	hntt_ram #(
		.W (ENT_W),
		.D (POOL)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [CNT_W-1:0] head_sel;
	logic             head_live;
	logic             name_eq;
	logic             link_live;
	logic             pool_full;
	assign head_sel  = head_q[h_q];
	assign head_live = head_sel < count_q;   // empty marker fails too
	assign name_eq   = rd_name == norm_q;
	assign link_live = rd_link < count_q;
	assign pool_full = count_q >= CNT_W'(POOL);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_HASH;
			S_HASH: state_d = (cur_byte == 8'd0) ? S_HEAD : S_RED;
			S_RED:  state_d = S_HASH;
			S_HEAD: state_d = head_live ? S_CMP : S_EMIT;
			S_CMP: begin
				if (name_eq || !link_live) state_d = S_EMIT;
			end
			S_EMIT: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	logic accept;
	logic hit;
	logic miss;
	logic load_out;
	logic mul_en;
	logic red_en;
	logic adv_en;
	always_comb begin
		accept    = 1'b0;
		hit       = 1'b0;
		miss      = 1'b0;
		load_out  = 1'b0;
		mul_en    = 1'b0;
		red_en    = 1'b0;
		adv_en    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: accept = in_valid;
			S_HASH: mul_en = 1'b1;
			S_RED:  red_en = 1'b1;
			S_HEAD: begin
				ram_raddr = head_sel[IDX_W-1:0];
				adv_en    = head_live;
				miss      = !head_live;
			end
			S_CMP: begin
				ram_raddr = rd_link[IDX_W-1:0];
				hit       = name_eq;
				adv_en    = !name_eq && link_live;
				miss      = !name_eq && !link_live;
			end
			S_EMIT: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Insert at the head of the bucket on a miss with room left
	assign ram_we    = miss && !pool_full;
	assign ram_waddr = count_q[IDX_W-1:0];
	assign ram_wdata = {norm_q, head_sel};

	assign in_ready = (state_q == S_IDLE);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < BUCKETS; b++) begin
				head_q[b] <= EMPTY;
			end
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				head_q[h_q] <= count_q;
				count_q     <= count_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			norm_q <= norm_in;
			h_q    <= H_W'(H0);
			byte_q <= 3'd0;
		end
		if (mul_en) begin
			x_q    <= x_new;
			prod_q <= PROD_W'(x_new) * PROD_W'(RECIP);
		end
		if (red_en) begin
			h_q    <= H_W'(rem);
			byte_q <= byte_q + 3'd1;
		end
		if (state_q == S_HEAD) begin
			cur_q <= head_sel[IDX_W-1:0];
		end else if (adv_en) begin
			cur_q <= rd_link[IDX_W-1:0];
		end
		if (hit) begin
			res_id_q   <= ID_W'(cur_q);
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else if (miss) begin
			res_id_q   <= pool_full ? '0 : ID_W'(count_q);
			res_new_q  <= !pool_full;
			res_full_q <= pool_full;
		end
		if (load_out) begin
			entry_id_q   <= res_id_q;
			was_new_q    <= res_new_q;
			table_full_q <= res_full_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign entry_id   = entry_id_q;
	assign was_new    = was_new_q;
	assign table_full = table_full_q;

endmodule
